/* design/prs_pkg.sv */
package prs_pkg;

   localparam int STEP_W     = 26;
   localparam int FRAC_BITS  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // request kinds
   localparam logic [1:0] REQ_TEXEL_WR = 2'd0;
   localparam logic [1:0] REQ_PAL_WR   = 2'd1;
   localparam logic [1:0] REQ_FETCH    = 2'd2;

   // fetch status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE  = 2'd1;
   localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_COLORS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIN_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIN_HEIGHT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TEX_SIZE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIP_SHIFT     = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [16:0] st_addr;
      logic [31:0] st_val;
   } item_type;

   typedef struct packed {
      logic              busy;
      logic [STEP_W-1:0] step;
   } step_stat_type;

endpackage

/* design/prs_if.sv */
interface prs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [16:0] store_address;
   logic [31:0] store_value;
   logic [7:0]  out_row;
   logic [8:0]  out_col;
   modport source (output valid, req_type, store_address, store_value, out_row, out_col,
                   input ready);
   modport sink (input valid, req_type, store_address, store_value, out_row, out_col,
                 output ready);
endinterface

interface prs_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_rgba;
   logic [1:0]  fetch_status;
   modport source (output valid, pixel_rgba, fetch_status, input ready);
   modport sink (input valid, pixel_rgba, fetch_status, output ready);
endinterface

interface prs_csr_if;
   logic                            valid;
   logic                            ready;
   logic [prs_pkg::CSR_IDX_W-1:0]  index;
   logic [prs_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* design/palette_remap_nearest_scaler.sv */
// a fetch request passes through the registered stage chain to its response
// throughput: one request per cycle; a stalled response backs up the stage chain
// writes produce no response and land in the texel or palette ram in request order
// synchronous reset clears all valid bits and loads register defaults; the column
// step is then recomputed (also after every csr write), with req.ready low
module palette_remap_nearest_scaler #(
   parameter int MAX_SKIN_TEXELS = 131072,
   parameter int OUT_MAX_WIDTH   = 512,
   parameter int OUT_MAX_HEIGHT  = 256,
   parameter int TOP_START       = 16,
   parameter int BOTTOM_START    = 96
) (
   input logic       clock,
   input logic       reset,
   prs_req_if.sink   req,
   prs_rsp_if.source rsp,
   prs_csr_if.sink   csr
);

   localparam int AW   = $clog2(MAX_SKIN_TEXELS);
   localparam int SW_W = $clog2(OUT_MAX_WIDTH + 1);
   localparam int SH_W = $clog2(OUT_MAX_HEIGHT + 1);
   localparam int RK   = 40;
   localparam logic [63:0] RECIP = (64'd1 << RK) / 64'(MAX_SKIN_TEXELS);
   localparam int NSTG = 11;

   function automatic logic [25:0] div3(logic [16:0] rem, logic [8:0] quo, int hi,
                                        logic [SH_W-1:0] den);
      logic [19:0] r;
      logic [19:0] d;
      logic [8:0]  q;
      r = 20'(rem);
      q = quo;
      for (int k = 0; k < 3; k++) begin
         d = 20'(den) << (hi - k);
         if (r >= d) begin
            r = r - d;
            q[4'(hi - k)] = 1'b1;
         end
      end
      return {r[16:0], q};
   endfunction

   function automatic logic [7:0] remap(logic [7:0] t, logic [7:0] colors);
      logic [7:0] top;
      logic [7:0] bot;
      logic [3:0] i;
      logic [7:0] res;
      top = {colors[7:4], 4'd0};
      bot = {colors[3:0], 4'd0};
      res = t;
      if (9'(t) >= 9'(BOTTOM_START) && 9'(t) < 9'(BOTTOM_START + 16)) begin
         i   = 4'(t - 8'(BOTTOM_START));
         res = bot[7] ? bot + 8'(4'd15 - i) : bot + 8'(i);
      end else if (9'(t) >= 9'(TOP_START) && 9'(t) < 9'(TOP_START + 16)) begin
         i   = 4'(t - 8'(TOP_START));
         res = top[7] ? top + 8'(4'd15 - i) : top + 8'(i);
      end
      return res;
   endfunction

   // config registers
   logic [7:0]  colors_ff;
   logic [9:0]  width_ff;
   logic [8:0]  height_ff;
   logic [14:0] mts_ff;
   logic [2:0]  mip_ff;

   logic csr_fire;
   assign csr.ready = 1'b1;
   assign csr_fire  = csr.valid && csr.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         colors_ff <= 8'd0;
         width_ff  <= 10'd320;
         height_ff <= 9'd200;
         mts_ff    <= 15'd1024;
         mip_ff    <= 3'd0;
      end else if (csr_fire) begin
         case (csr.index)
            prs_pkg::CSR_PLAYER_COLORS: colors_ff <= csr.data[7:0];
            prs_pkg::CSR_SKIN_WIDTH:    width_ff  <= csr.data[9:0];
            prs_pkg::CSR_SKIN_HEIGHT:   height_ff <= csr.data[8:0];
            prs_pkg::CSR_MAX_TEX_SIZE:  mts_ff    <= csr.data[14:0];
            prs_pkg::CSR_MIP_SHIFT:     mip_ff    <= csr.data[2:0];
            default: ;
         endcase
      end
   end

   // scaled output size
   logic [SW_W-1:0] sw;
   logic [SH_W-1:0] sh;
   always_comb begin
      sw = (16'(mts_ff) < 16'(OUT_MAX_WIDTH)) ? SW_W'(mts_ff) : SW_W'(OUT_MAX_WIDTH);
      sh = (16'(mts_ff) < 16'(OUT_MAX_HEIGHT)) ? SH_W'(mts_ff) : SH_W'(OUT_MAX_HEIGHT);
      sw = sw >> mip_ff;
      sh = sh >> mip_ff;
   end

   prs_pkg::step_stat_type step_stat;

   prs_step_div #(.SW_W(SW_W)) u_step_div (
      .clock      (clock),
      .reset      (reset),
      .start      (csr_fire),
      .skin_width (width_ff),
      .out_width  (sw),
      .stat       (step_stat)
   );

   // stage handshake
   logic [NSTG:1]      v_ff, v_in;
   logic [NSTG:1]      en;
   prs_pkg::item_type  it_ff [1:10];
   prs_pkg::item_type  it_in;
   logic               fire;
   logic               keep;
   logic [3:0]         size_prod;

   always_comb begin
      en[NSTG] = !v_ff[NSTG] || rsp.ready;
      for (int i = NSTG - 1; i >= 1; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req.ready = en[1] && !step_stat.busy;
   assign fire      = req.valid && req.ready;

   always_comb begin
      keep = (req.req_type == prs_pkg::REQ_FETCH) || (req.req_type == prs_pkg::REQ_PAL_WR) ||
             ((req.req_type == prs_pkg::REQ_TEXEL_WR) &&
              (20'(req.store_address) < 20'(MAX_SKIN_TEXELS)));
      size_prod = 4'(width_ff[1:0]) * 4'(height_ff[1:0]);
      it_in.kind    = req.req_type;
      it_in.st_addr = req.store_address;
      it_in.st_val  = req.store_value;
      // size check wins over the bounds check
      if (size_prod[1:0] != 2'd0) begin
         it_in.status = prs_pkg::STATUS_BAD_SIZE;
      end else if (16'(req.out_row) >= 16'(sh) || 16'(req.out_col) >= 16'(sw)) begin
         it_in.status = prs_pkg::STATUS_OUTSIDE;
      end else begin
         it_in.status = prs_pkg::STATUS_OK;
      end
      v_in[1] = fire && keep;
      for (int i = 2; i <= 10; i++) begin
         v_in[i] = v_ff[i-1];
      end
      v_in[NSTG] = v_ff[10] && (it_ff[10].kind == prs_pkg::REQ_FETCH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 1; i <= NSTG; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         it_ff[1] <= it_in;
      end
      for (int i = 2; i <= 10; i++) begin
         if (en[i]) begin
            it_ff[i] <= it_ff[i-1];
         end
      end
   end

   // address datapath
   logic [7:0]  row1_ff;
   logic [8:0]  col1_ff;
   logic [16:0] rowprod2_ff, rowprod2_in;
   logic [34:0] colprod2_ff, colprod2_in;
   logic [35:0] frac;
   logic [9:0]  colidx3_ff, colidx4_ff, colidx5_ff;
   logic [16:0] rem3_ff, rem4_ff;
   logic [8:0]  quo3_ff, quo4_ff, srow5_ff;
   logic [25:0] dv3_in, dv4_in, dv5_in;
   logic [19:0] sum6_ff, sum6_in, sum7_ff, sum8_ff;
   logic [50:0] prod7;
   logic [9:0]  q7_ff;
   logic [28:0] qm8_ff, qm8_in;
   logic [20:0] r_diff;
   logic [AW-1:0] taddr9_ff, taddr9_in;

   always_comb begin
      rowprod2_in = 17'(row1_ff) * 17'(height_ff);
      colprod2_in = 35'(col1_ff) * 35'(step_stat.step);
      frac        = 36'(colprod2_ff) + 36'(step_stat.step >> 1);
      dv3_in      = div3(rowprod2_ff, 9'd0, 8, sh);
      dv4_in      = div3(rem3_ff, quo3_ff, 5, sh);
      dv5_in      = div3(rem4_ff, quo4_ff, 2, sh);
      sum6_in     = 20'(width_ff) * 20'(srow5_ff) + 20'(colidx5_ff);
      prod7       = 51'(sum6_ff) * 51'(RECIP[30:0]);
      qm8_in      = 29'(q7_ff) * 29'(MAX_SKIN_TEXELS);
      // quotient estimate is low by at most one
      r_diff      = 21'(sum8_ff) - 21'(qm8_ff);
      taddr9_in   = (r_diff >= 21'(MAX_SKIN_TEXELS)) ? AW'(r_diff - 21'(MAX_SKIN_TEXELS))
                                                     : AW'(r_diff);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         row1_ff <= req.out_row;
         col1_ff <= req.out_col;
      end
      if (en[2]) begin
         rowprod2_ff <= rowprod2_in;
         colprod2_ff <= colprod2_in;
      end
      if (en[3]) begin
         colidx3_ff <= frac[25:16];
         rem3_ff    <= dv3_in[25:9];
         quo3_ff    <= dv3_in[8:0];
      end
      if (en[4]) begin
         colidx4_ff <= colidx3_ff;
         rem4_ff    <= dv4_in[25:9];
         quo4_ff    <= dv4_in[8:0];
      end
      if (en[5]) begin
         colidx5_ff <= colidx4_ff;
         srow5_ff   <= dv5_in[8:0];
      end
      if (en[6]) begin
         sum6_ff <= sum6_in;
      end
      if (en[7]) begin
         sum7_ff <= sum6_ff;
         q7_ff   <= prod7[RK+9:RK];
      end
      if (en[8]) begin
         sum8_ff <= sum7_ff;
         qm8_ff  <= qm8_in;
      end
      if (en[9]) begin
         taddr9_ff <= taddr9_in;
      end
   end

   // texel ram: reads and writes at the same stage keep request order
   logic          tex_we;
   logic [AW-1:0] tex_addr;
   logic [7:0]    tex_q;

   assign tex_we   = v_ff[9] && (it_ff[9].kind == prs_pkg::REQ_TEXEL_WR);
   assign tex_addr = (it_ff[9].kind == prs_pkg::REQ_TEXEL_WR) ? AW'(it_ff[9].st_addr)
                                                              : taddr9_ff;

   prs_ram #(.WIDTH(8), .DEPTH(MAX_SKIN_TEXELS)) u_texel_ram (
      .clock (clock),
      .en    (en[10]),
      .we    (tex_we),
      .addr  (tex_addr),
      .wdata (it_ff[9].st_val[7:0]),
      .rdata (tex_q)
   );

   // palette ram
   logic        pal_we;
   logic [7:0]  pal_addr;
   logic [31:0] pal_q;
   logic [1:0]  status11_ff;

   assign pal_we   = v_ff[10] && (it_ff[10].kind == prs_pkg::REQ_PAL_WR);
   assign pal_addr = (it_ff[10].kind == prs_pkg::REQ_PAL_WR) ? it_ff[10].st_addr[7:0]
                                                             : remap(tex_q, colors_ff);

   prs_ram #(.WIDTH(32), .DEPTH(256)) u_palette_ram (
      .clock (clock),
      .en    (en[NSTG]),
      .we    (pal_we),
      .addr  (pal_addr),
      .wdata (it_ff[10].st_val),
      .rdata (pal_q)
   );

   always_ff @(posedge clock) begin
      if (en[NSTG]) begin
         status11_ff <= it_ff[10].status;
      end
   end

   assign rsp.valid        = v_ff[NSTG];
   assign rsp.fetch_status = status11_ff;
   assign rsp.pixel_rgba   = (status11_ff == prs_pkg::STATUS_OK) ? pal_q : 32'd0;

endmodule

/* design/prs_ram.sv */
module prs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end
         rdata <= mem[addr];
      end
   end

endmodule

/* design/prs_step_div.sv */
module prs_step_div #(
   parameter int SW_W = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [9:0]             skin_width,
   input  logic [SW_W-1:0]        out_width,
   output prs_pkg::step_stat_type stat
);

   logic [prs_pkg::STEP_W-1:0] numer;
   logic [4:0]                 idx;
   logic [SW_W:0]              shifted;
   logic                       ge;
   logic [SW_W-1:0]            rem_ff, rem_in;
   logic [prs_pkg::STEP_W-1:0] quo_ff, quo_in;
   logic [4:0]                 cnt_ff;
   logic                       busy_ff;

   // restoring division, one quotient bit per cycle, config read live
   always_comb begin
      numer   = {skin_width, {prs_pkg::FRAC_BITS{1'b0}}};
      idx     = 5'(prs_pkg::STEP_W - 1) - cnt_ff;
      shifted = {rem_ff, numer[idx]};
      ge      = shifted >= {1'b0, out_width};
      rem_in  = ge ? SW_W'(shifted - {1'b0, out_width}) : SW_W'(shifted);
      quo_in  = {quo_ff[prs_pkg::STEP_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset || start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'(prs_pkg::STEP_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.step = quo_ff;

endmodule

/* design/prs_checker.sv */
module prs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] pixel_rgba,
   input logic [1:0]  fetch_status,
   input logic        csr_valid,
   input logic        csr_ready
);

   // a held response stays until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // nothing comes out of a freshly reset pipeline
   a_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

   // step recompute blocks requests after a csr transfer
   a_csr_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("request taken during step recompute");

   // error responses carry no color
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fetch_status != prs_pkg::STATUS_OK |-> pixel_rgba == 32'd0)
      else $error("nonzero pixel on error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> fetch_status == prs_pkg::STATUS_OK ||
                    fetch_status == prs_pkg::STATUS_OUTSIDE ||
                    fetch_status == prs_pkg::STATUS_BAD_SIZE)
      else $error("undefined fetch status");

endmodule

bind palette_remap_nearest_scaler prs_checker u_prs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .pixel_rgba   (rsp.pixel_rgba),
   .fetch_status (rsp.fetch_status),
   .csr_valid    (csr.valid),
   .csr_ready    (csr.ready)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int TEXELS      = 131072;
   localparam int OUT_W_MAX   = 512;
   localparam int OUT_H_MAX   = 256;
   localparam int TOP_BASE    = 16;
   localparam int BOTTOM_BASE = 96;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 165;

   typedef logic [prs_pkg::CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [prs_pkg::CSR_DATA_W-1:0] csr_data_type;

   typedef struct {
      logic [1:0]  kind;
      logic [16:0] addr;
      logic [31:0] value;
      logic [7:0]  row;
      logic [8:0]  col;
   } request_type;

   typedef struct {
      logic [31:0] rgba;
      logic [1:0]  status;
   } pixel_type;

   class scaler_scoreboard;
      logic [7:0]  colors;
      logic [9:0]  width;
      logic [8:0]  height;
      logic [14:0] max_size;
      logic [2:0]  mip;
      logic [7:0]  texels [TEXELS];
      bit          texel_known [TEXELS];
      logic [31:0] palette [256];
      bit          pal_known [256];
      pixel_type   pending_pixels [$];
      int          errors;

      function void reset_state();
         colors = 0; width = 320; height = 200; max_size = 1024; mip = 0;
      endfunction

      function void write_csr(csr_idx_type idx, csr_data_type data);
         case (idx)
            prs_pkg::CSR_PLAYER_COLORS: colors = data[7:0];
            prs_pkg::CSR_SKIN_WIDTH: width = data[9:0];
            prs_pkg::CSR_SKIN_HEIGHT: height = data[8:0];
            prs_pkg::CSR_MAX_TEX_SIZE: max_size = data[14:0];
            prs_pkg::CSR_MIP_SHIFT: mip = data[2:0];
            default: ;
         endcase
      endfunction

      function bit size_bad();
         int unsigned area;
         area = 32'(width) * 32'(height);
         return area[1:0] != 0;
      endfunction

      function int unsigned scaled_w();
         int unsigned s;
         s = (max_size < OUT_W_MAX) ? 32'(max_size) : OUT_W_MAX;
         return s >> mip;
      endfunction

      function int unsigned scaled_h();
         int unsigned s;
         s = (max_size < OUT_H_MAX) ? 32'(max_size) : OUT_H_MAX;
         return s >> mip;
      endfunction

      // returns 1 when the fetch actually reads the stores
      function bit texel_addr(logic [7:0] row, logic [8:0] col, output int unsigned addr);
         longint unsigned step, frac, src_row, sw, sh;
         sw = scaled_w();
         sh = scaled_h();
         addr = 0;
         if (size_bad() || row >= sh || col >= sw) return 0;
         step = (64'(width) * 64'h10000) / sw;
         frac = (step >> 1) + 64'(col) * step;
         src_row = (64'(row) * 64'(height)) / sh;
         addr = 32'((64'(width) * src_row + (frac >> 16)) % TEXELS);
         return 1;
      endfunction

      function logic [7:0] remap(logic [7:0] t);
         logic [7:0] top, bottom, i;
         top = colors & 8'hf0;
         bottom = {colors[3:0], 4'h0};
         if (t >= BOTTOM_BASE && t < BOTTOM_BASE + 16) begin
            i = 8'(t - BOTTOM_BASE);
            return (bottom < 128) ? 8'(bottom + i) : 8'(bottom + 15 - i);
         end
         if (t >= TOP_BASE && t < TOP_BASE + 16) begin
            i = 8'(t - TOP_BASE);
            return (top < 128) ? 8'(top + i) : 8'(top + 15 - i);
         end
         return t;
      endfunction

      function void note_request(request_type r);
         pixel_type p;
         int unsigned a;
         case (r.kind)
            prs_pkg::REQ_TEXEL_WR: begin
               texels[r.addr] = r.value[7:0];
               texel_known[r.addr] = 1;
            end
            prs_pkg::REQ_PAL_WR: begin
               palette[r.addr[7:0]] = r.value;
               pal_known[r.addr[7:0]] = 1;
            end
            prs_pkg::REQ_FETCH: begin
               p.rgba = 0;
               if (size_bad()) p.status = prs_pkg::STATUS_BAD_SIZE;
               else if (!texel_addr(r.row, r.col, a)) p.status = prs_pkg::STATUS_OUTSIDE;
               else begin
                  p.status = prs_pkg::STATUS_OK;
                  p.rgba = palette[remap(texels[a])];
               end
               pending_pixels.push_back(p);
            end
            default: ;
         endcase
      endfunction

      function void check_pixel(logic [31:0] rgba, logic [1:0] status);
         pixel_type p;
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel: pixel_rgba %h fetch_status %0d", rgba, status);
            errors++;
            return;
         end
         p = pending_pixels.pop_front();
         if (status !== p.status) begin
            $error("fetch_status: expected %0d, actual %0d", p.status, status);
            errors++;
         end
         if (rgba !== p.rgba) begin
            $error("pixel_rgba: expected %h, actual %h", p.rgba, rgba);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   prs_req_if req_ch();
   prs_rsp_if rsp_ch();
   prs_csr_if csr_ch();

   palette_remap_nearest_scaler uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr(csr_ch)
   );

   scaler_scoreboard pixels_sb;
   int burst_left;
   bit gaps_on;
   int hold_requests;
   int sent;
   longint cycles;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("palette_remap_nearest_scaler: mismatch");
         $finish;
      end
   end

   // receiver: stall pattern changes every so often, long hold-off on request
   int stall_mode;
   int mode_left;
   int hold_left;
   int holds_seen;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
         stall_mode <= 0;
         mode_left <= 0;
         hold_left <= 0;
         holds_seen <= 0;
      end else if (hold_requests != holds_seen) begin
         holds_seen <= hold_requests;
         hold_left <= 300;
         rsp_ch.ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= (hold_left == 1);
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_ch.ready <= 1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         pixels_sb.check_pixel(rsp_ch.pixel_rgba, rsp_ch.fetch_status);
   end

   task automatic send(request_type r);
      int gap;
      req_ch.valid <= 1;
      req_ch.req_type <= r.kind;
      req_ch.store_address <= r.addr;
      req_ch.store_value <= r.value;
      req_ch.out_row <= r.row;
      req_ch.out_col <= r.col;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pixels_sb.note_request(r);
      sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 40);
         gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_kind(logic [1:0] kind, logic [16:0] addr, logic [31:0] value,
                            logic [7:0] row, logic [8:0] col);
      request_type r;
      r.kind = kind; r.addr = addr; r.value = value; r.row = row; r.col = col;
      send(r);
   endtask

   function automatic logic [7:0] texel_value();
      case ($urandom_range(0, 3))
         0: return 8'(TOP_BASE + $urandom_range(0, 15));
         1: return 8'(BOTTOM_BASE + $urandom_range(0, 15));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // loads any texel or palette entry the fetch would read before it was ever written
   task automatic fetch(logic [7:0] row, logic [8:0] col);
      int unsigned a;
      logic [7:0] idx;
      if (pixels_sb.texel_addr(row, col, a)) begin
         if (!pixels_sb.texel_known[a])
            send_kind(prs_pkg::REQ_TEXEL_WR, 17'(a), {24'($urandom), texel_value()},
                      8'($urandom), 9'($urandom));
         idx = pixels_sb.remap(pixels_sb.texels[a]);
         if (!pixels_sb.pal_known[idx])
            send_kind(prs_pkg::REQ_PAL_WR, {9'($urandom_range(0, 511)), idx}, $urandom,
                      8'($urandom), 9'($urandom));
      end
      send_kind(prs_pkg::REQ_FETCH, 17'($urandom), $urandom, row, col);
   endtask

   task automatic drain();
      while (pixels_sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic configure(logic [7:0] colors, logic [9:0] w, logic [8:0] h,
                            logic [14:0] max_size, logic [2:0] mip);
      csr_data_type vals [5];
      csr_idx_type  idxs [5];
      req_ch.valid <= 0;
      drain();
      idxs = '{prs_pkg::CSR_PLAYER_COLORS, prs_pkg::CSR_SKIN_WIDTH, prs_pkg::CSR_SKIN_HEIGHT,
               prs_pkg::CSR_MAX_TEX_SIZE, prs_pkg::CSR_MIP_SHIFT};
      vals = '{csr_data_type'(colors), csr_data_type'(w), csr_data_type'(h),
               csr_data_type'(max_size), csr_data_type'(mip)};
      for (int i = 0; i < 5; i++) begin
         csr_ch.valid <= 1;
         csr_ch.index <= idxs[i];
         csr_ch.data <= vals[i];
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
         pixels_sb.write_csr(idxs[i], vals[i]);
      end
      csr_ch.valid <= 0;
   endtask

   task automatic random_item();
      int unsigned sw, sh;
      sw = pixels_sb.scaled_w();
      sh = pixels_sb.scaled_h();
      case ($urandom_range(0, 19))
         0, 1, 2: send_kind(prs_pkg::REQ_TEXEL_WR, 17'($urandom), $urandom, 8'($urandom),
                            9'($urandom));
         3, 4: send_kind(prs_pkg::REQ_PAL_WR, 17'($urandom), $urandom, 8'($urandom),
                         9'($urandom));
         5: send_kind(REQ_UNUSED, 17'($urandom), $urandom, 8'($urandom), 9'($urandom));
         6, 7: fetch(8'($urandom), 9'($urandom));
         default: begin
            if (sw > 0 && sh > 0)
               fetch(8'($urandom_range(0, sh - 1)), 9'($urandom_range(0, sw - 1)));
            else
               fetch(8'($urandom), 9'($urandom));
         end
      endcase
   endtask

   initial begin
      logic [9:0] w;
      logic [8:0] h;
      logic [14:0] ms;
      int phase_start;
      pixels_sb = new();
      pixels_sb.reset_state();
      cycles = 0;
      burst_left = 0;
      gaps_on = 1;
      hold_requests = 0;
      sent = 0;
      reset = 1;
      req_ch.valid = 0;
      req_ch.req_type = prs_pkg::REQ_FETCH;
      req_ch.store_address = 0;
      req_ch.store_value = 0;
      req_ch.out_row = 0;
      req_ch.out_col = 0;
      csr_ch.valid = 0;
      csr_ch.index = prs_pkg::CSR_PLAYER_COLORS;
      csr_ch.data = 0;
      repeat (2) @(posedge clock);
      reset <= 0;

      // reset settings, every request kind, field extremes
      fetch(0, 0);
      fetch(255, 511);
      send_kind(prs_pkg::REQ_TEXEL_WR, 17'h1ffff, 32'hffffffff, 8'hff, 9'h1ff);
      send_kind(prs_pkg::REQ_PAL_WR, 17'h1ffff, 32'hffffffff, 8'hff, 9'h1ff);
      send_kind(REQ_UNUSED, 17'h1ffff, 32'hffffffff, 8'hff, 9'h1ff);
      fetch(100, 200);
      // reversed ranges, smallest skin and texture
      configure(8'h9a, 10'd4, 9'd1, 15'd16, 3'd0);
      fetch(0, 0);
      fetch(15, 15);
      fetch(16, 0);
      fetch(0, 16);
      // largest skin, biggest shift
      configure(8'h25, 10'd512, 9'd256, 15'd16384, 3'd7);
      fetch(0, 0);
      fetch(1, 3);
      fetch(2, 0);
      // skin area not a multiple of four
      configure(8'hff, 10'd5, 9'd3, 15'd1024, 3'd0);
      fetch(0, 0);
      // scaled size collapses to zero
      configure(8'h00, 10'd4, 9'd4, 15'd16, 3'd7);
      fetch(0, 0);

      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 3))
            0: w = 10'd4;
            1: w = 10'd512;
            default: w = 10'($urandom_range(4, 64));
         endcase
         if ($urandom_range(0, 4) != 0 && w > 7) w[1:0] = 0;
         h = ($urandom_range(0, 5) == 0) ? 9'd256 : 9'($urandom_range(1, 16));
         case ($urandom_range(0, 3))
            0: ms = 15'd16;
            1: ms = 15'd16384;
            default: ms = 15'($urandom_range(16, 600));
         endcase
         configure(8'($urandom), w, h, ms,
                   ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(0, 2)));
         gaps_on = (phase % 3 != 1);
         phase_start = sent;
         while (sent - phase_start < PHASE_ITEMS) begin
            if (phase == 2 && hold_requests == 0 && sent - phase_start >= 20) hold_requests++;
            random_item();
         end
      end
      req_ch.valid <= 0;

      while (pixels_sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (pixels_sb.pending_pixels.size() != 0) begin
         $error("%0d expected pixels never arrived", pixels_sb.pending_pixels.size());
         pixels_sb.errors++;
      end
      if (pixels_sb.errors == 0)
         $display("palette_remap_nearest_scaler: match");
      else
         $display("palette_remap_nearest_scaler: mismatch");
      $finish;
   end

endmodule
